>>> rtl/ppc_pkg.sv
// ----------------------------------------------------------------------------
// ppc_pkg
// Shared types and constants for the PID controller with PWM output.
// ----------------------------------------------------------------------------
`default_nettype none

package ppc_pkg;

   // fixed field widths
   localparam int MEAS_W      = 12;
   localparam int SETPOINT_W  = 12;
   localparam int GAIN_W      = 32;
   localparam int COUNT_W     = 16;
   localparam int SUM_W       = 32;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int OP_W        = 2;
   localparam int FRAC_W      = 16;
   // widest sample width that the parameter may take
   localparam int SAMPLE_MAX_W = 16;
   // accumulator: holds the exact sum of all three products
   localparam int ACC_W       = 67;

   localparam int SAMPLE_BITS_DEF = 12;

   // reset values of the configuration registers
   localparam logic [SETPOINT_W-1:0] SETPOINT_RST    = '0;
   localparam logic [GAIN_W-1:0]     PROP_GAIN_RST   = 32'd2293760;
   localparam logic [GAIN_W-1:0]     INTEG_GAIN_RST  = 32'd11010;
   localparam logic [GAIN_W-1:0]     DERIV_GAIN_RST  = 32'd4300800;
   localparam logic [COUNT_W-1:0]    CTRL_PERIOD_RST = 16'd480;
   localparam logic [COUNT_W-1:0]    PWM_PERIOD_RST  = 16'd200;
   localparam logic [COUNT_W-1:0]    LOW_OUTPUT_RST  = 16'd1;

   typedef enum logic [OP_W-1:0] {
      OP_PWM_TICK    = 2'd0,
      OP_PERIOD_TICK = 2'd1,
      OP_CALC        = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SETPOINT    = 3'd0,
      CSR_PROP_GAIN   = 3'd1,
      CSR_INTEG_GAIN  = 3'd2,
      CSR_DERIV_GAIN  = 3'd3,
      CSR_CTRL_PERIOD = 3'd4,
      CSR_PWM_PERIOD  = 3'd5,
      CSR_LOW_OUTPUT  = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic [SETPOINT_W-1:0] setpoint;
      logic [GAIN_W-1:0]     prop_gain;
      logic [GAIN_W-1:0]     integ_gain;
      logic [GAIN_W-1:0]     deriv_gain;
      logic [COUNT_W-1:0]    control_period;
      logic [COUNT_W-1:0]    pwm_period;
      logic [COUNT_W-1:0]    low_output;
   } cfg_type;

endpackage

`default_nettype wire

>>> rtl/ppc_csr.sv
// ----------------------------------------------------------------------------
// ppc_csr
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module ppc_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write,
   input  wire logic [ppc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ppc_pkg::CSR_DATA_W-1:0] csr_data,
   output ppc_pkg::cfg_type                    cfg
);
   import ppc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_idx_type'(csr_index))
            CSR_SETPOINT:    cfg_in.setpoint       = csr_data[SETPOINT_W-1:0];
            CSR_PROP_GAIN:   cfg_in.prop_gain      = csr_data[GAIN_W-1:0];
            CSR_INTEG_GAIN:  cfg_in.integ_gain     = csr_data[GAIN_W-1:0];
            CSR_DERIV_GAIN:  cfg_in.deriv_gain     = csr_data[GAIN_W-1:0];
            CSR_CTRL_PERIOD: cfg_in.control_period = csr_data[COUNT_W-1:0];
            CSR_PWM_PERIOD:  cfg_in.pwm_period     = csr_data[COUNT_W-1:0];
            CSR_LOW_OUTPUT:  cfg_in.low_output     = csr_data[COUNT_W-1:0];
            default: ;  // writes beyond the register list are dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setpoint       <= SETPOINT_RST;
         cfg_ff.prop_gain      <= PROP_GAIN_RST;
         cfg_ff.integ_gain     <= INTEG_GAIN_RST;
         cfg_ff.deriv_gain     <= DERIV_GAIN_RST;
         cfg_ff.control_period <= CTRL_PERIOD_RST;
         cfg_ff.pwm_period     <= PWM_PERIOD_RST;
         cfg_ff.low_output     <= LOW_OUTPUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> rtl/ppc_core.sv
// ----------------------------------------------------------------------------
// ppc_core
// Controller state and single-pass datapath: PWM counter, period counter,
// error accumulator and the three-term PID sum with duty clamping.
// ----------------------------------------------------------------------------
`default_nettype none

module ppc_core #(
   parameter int SAMPLE_BITS = ppc_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        step,
   input  wire logic [ppc_pkg::OP_W-1:0]    op,
   input  wire logic [ppc_pkg::MEAS_W-1:0]  measured,
   input  wire ppc_pkg::cfg_type            cfg,
   output logic                             pin_level,
   output logic [ppc_pkg::COUNT_W-1:0]      duty_now,
   output logic                             updated
);
   import ppc_pkg::*;

   localparam int ERR_W  = SAMPLE_BITS + 1;
   localparam int DIFF_W = SAMPLE_BITS + 2;
   localparam int P_W    = GAIN_W + 1 + ERR_W;
   localparam int I_W    = GAIN_W + 1 + SUM_W;
   localparam int D_W    = GAIN_W + 1 + DIFF_W;

   logic [COUNT_W-1:0]      pwm_count_ff, pwm_count_in;
   logic [COUNT_W-1:0]      period_count_ff, period_count_in;
   logic signed [SUM_W-1:0] error_sum_ff, error_sum_in;
   logic signed [ERR_W-1:0] last_error_ff, last_error_in;
   logic [COUNT_W-1:0]      duty_ff, duty_in;
   logic                    pin_ff, pin_in;

   logic [COUNT_W-1:0]      pwm_inc;
   logic [SAMPLE_MAX_W-1:0] meas_wide;
   logic [SAMPLE_MAX_W-1:0] setp_wide;
   logic [SAMPLE_BITS-1:0]  meas_smp;
   logic [SAMPLE_BITS-1:0]  setp_smp;
   logic signed [ERR_W-1:0] err;
   logic signed [SUM_W:0]   sum_raw;
   logic signed [SUM_W-1:0] sum_sat;
   logic signed [DIFF_W-1:0] diff;
   logic signed [P_W-1:0]   p_term;
   logic signed [I_W-1:0]   i_term;
   logic signed [D_W-1:0]   d_term;
   logic signed [ACC_W-1:0] acc;
   logic signed [ACC_W-1:0] acc_limit;
   logic                    calc_go;

   // sample path: zero-extend to the widest sample, then keep SAMPLE_BITS
   assign meas_wide = SAMPLE_MAX_W'(measured);
   assign setp_wide = SAMPLE_MAX_W'(cfg.setpoint);
   assign meas_smp  = meas_wide[SAMPLE_BITS-1:0];
   assign setp_smp  = setp_wide[SAMPLE_BITS-1:0];

   assign err = $signed({1'b0, meas_smp}) - $signed({1'b0, setp_smp});

   // saturating error accumulator
   assign sum_raw = $signed({error_sum_ff[SUM_W-1], error_sum_ff})
                  + (SUM_W + 1)'(err);
   always_comb begin
      if (sum_raw[SUM_W] != sum_raw[SUM_W-1]) begin
         sum_sat = sum_raw[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                  : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sum_sat = sum_raw[SUM_W-1:0];
      end
   end

   assign diff = DIFF_W'(err) - DIFF_W'(last_error_ff);

   // three products in exact signed form, gains taken as unsigned
   assign p_term = $signed({1'b0, cfg.prop_gain})  * err;
   assign i_term = $signed({1'b0, cfg.integ_gain}) * sum_sat;
   assign d_term = $signed({1'b0, cfg.deriv_gain}) * diff;

   assign acc = ACC_W'(p_term) + ACC_W'(i_term) + ACC_W'(d_term);
   assign acc_limit = ACC_W'($signed({1'b0, cfg.pwm_period, {FRAC_W{1'b0}}}));

   assign pwm_inc = pwm_count_ff + COUNT_W'(1);
   assign calc_go = (period_count_ff >= cfg.control_period);

   always_comb begin
      pwm_count_in    = pwm_count_ff;
      period_count_in = period_count_ff;
      error_sum_in    = error_sum_ff;
      last_error_in   = last_error_ff;
      duty_in         = duty_ff;
      pin_in          = pin_ff;
      updated         = 1'b0;
      case (op_type'(op))
         OP_PWM_TICK: begin
            pwm_count_in = (pwm_inc >= cfg.pwm_period) ? '0 : pwm_inc;
            pin_in       = (pwm_count_in < duty_ff);
         end
         OP_PERIOD_TICK: begin
            if (period_count_ff != {COUNT_W{1'b1}}) begin
               period_count_in = period_count_ff + COUNT_W'(1);
            end
         end
         OP_CALC: begin
            if (calc_go) begin
               error_sum_in = sum_sat;
               if (acc > acc_limit) begin
                  duty_in = cfg.pwm_period;
               end else if (acc[ACC_W-1]) begin
                  duty_in = cfg.low_output;
               end else begin
                  duty_in = acc[FRAC_W+COUNT_W-1:FRAC_W];
               end
               last_error_in   = err;
               period_count_in = '0;
               updated         = 1'b1;
            end
         end
         default: ;  // unused op code leaves the state alone
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_count_ff    <= '0;
         period_count_ff <= '0;
         error_sum_ff    <= '0;
         last_error_ff   <= '0;
         duty_ff         <= '0;
         pin_ff          <= 1'b0;
      end else if (step) begin
         pwm_count_ff    <= pwm_count_in;
         period_count_ff <= period_count_in;
         error_sum_ff    <= error_sum_in;
         last_error_ff   <= last_error_in;
         duty_ff         <= duty_in;
         pin_ff          <= pin_in;
      end
   end

   assign pin_level = pin_in;
   assign duty_now  = duty_in;

endmodule

`default_nettype wire

>>> rtl/pid_pwm_controller.sv
// ----------------------------------------------------------------------------
// pid_pwm_controller
// Positional PID with a PWM pin, one transaction per cycle unless stalled.
// ----------------------------------------------------------------------------
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_op, req_measured
//   rsp      out        rsp_valid / rsp_stall  rsp_pin_level, rsp_duty_now,
//                                              rsp_updated
//   csr      in         csr_write              csr_index, csr_data
//
// A request transaction is registered in the input stage, processed in one
// pass through the datapath (three parallel multiplies, sum and clamp) and
// lands in the response register; one transaction per cycle is sustained
// while the response is not stalled. Synchronous reset clears all controller
// state and loads the default gains. A stalled response holds the input
// stage, which, if empty, still takes one more request before req_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_pwm_controller #(
   parameter int SAMPLE_BITS = ppc_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [ppc_pkg::OP_W-1:0]       req_op,
   input  wire logic [ppc_pkg::MEAS_W-1:0]     req_measured,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_pin_level,
   output logic [ppc_pkg::COUNT_W-1:0]         rsp_duty_now,
   output logic                                rsp_updated,
   input  wire logic                           csr_write,
   input  wire logic [ppc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ppc_pkg::CSR_DATA_W-1:0] csr_data
);
   import ppc_pkg::*;

   cfg_type cfg;

   logic                req_valid_ff;
   logic [OP_W-1:0]     req_op_ff;
   logic [MEAS_W-1:0]   req_meas_ff;
   logic                rsp_valid_ff;
   logic                rsp_pin_ff;
   logic [COUNT_W-1:0]  rsp_duty_ff;
   logic                rsp_upd_ff;

   logic                accept;
   logic                advance;
   logic                pin_in;
   logic [COUNT_W-1:0]  duty_in;
   logic                upd_in;

   ppc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ppc_core #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .op        (req_op_ff),
      .measured  (req_meas_ff),
      .cfg       (cfg),
      .pin_level (pin_in),
      .duty_now  (duty_in),
      .updated   (upd_in)
   );

   // input stage moves on whenever the response register is free or drains
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            req_valid_ff <= 1'b1;
         end else if (advance) begin
            req_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_op_ff   <= req_op;
         req_meas_ff <= req_measured;
      end
      if (advance) begin
         rsp_pin_ff  <= pin_in;
         rsp_duty_ff <= duty_in;
         rsp_upd_ff  <= upd_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pin_level = rsp_pin_ff;
   assign rsp_duty_now  = rsp_duty_ff;
   assign rsp_updated   = rsp_upd_ff;

   // a processed transaction always shows up on the response side
   a_advance_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed transaction missing from response register");

   // a freshly computed duty is at most the period or equals the low output
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_upd_ff) |->
         (rsp_duty_ff <= cfg.pwm_period) || (rsp_duty_ff == cfg.low_output))
      else $error("updated duty outside the allowed range");

   // both stages come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!req_valid_ff && !rsp_valid_ff))
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
